@@ design/utf8d_pkg.sv @@
// shared types and constants of the utf-8 code point decoder
package utf8d_pkg;

   localparam int ByteWidth = 8;
   localparam int CodeWidth = 21;
   localparam int PendWidth = 2;

   // continuation bytes still expected
   localparam logic [PendWidth-1:0] PEND_NONE  = 2'd0;
   localparam logic [PendWidth-1:0] PEND_ONE   = 2'd1;
   localparam logic [PendWidth-1:0] PEND_TWO   = 2'd2;
   localparam logic [PendWidth-1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [CodeWidth-1:0] partial_code;
      logic [PendWidth-1:0] bytes_pending;
   } state_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      logic                 has_code;
      logic                 string_end;
   } result_type;

endpackage

@@ design/utf8d_step.sv @@
// combinational decode of one byte against the partial code point state
module utf8d_step (
   input  logic [utf8d_pkg::ByteWidth-1:0] text_byte,
   input  utf8d_pkg::state_type            state_cur,
   output utf8d_pkg::state_type            state_nxt,
   output logic                            emit,
   output utf8d_pkg::result_type           result
);

   logic [utf8d_pkg::CodeWidth-1:0] cont_bits;
   logic [utf8d_pkg::CodeWidth-1:0] merged;

   // low 6 bits of a continuation byte placed by the count still expected
   always_comb begin
      case (state_cur.bytes_pending)
         utf8d_pkg::PEND_THREE: cont_bits = {3'b000, text_byte[5:0], 12'h000};
         utf8d_pkg::PEND_TWO:   cont_bits = {9'h000, text_byte[5:0], 6'h00};
         default:               cont_bits = {15'h0000, text_byte[5:0]};
      endcase
   end

   assign merged = state_cur.partial_code | cont_bits;

   always_comb begin
      state_nxt         = state_cur;
      emit              = 1'b0;
      result.code_point = '0;
      result.has_code   = 1'b0;
      result.string_end = 1'b0;
      if (text_byte == '0) begin
         emit              = 1'b1;
         result.string_end = 1'b1;
         if (state_cur.bytes_pending != utf8d_pkg::PEND_NONE) begin
            result.code_point = state_cur.partial_code;
            result.has_code   = 1'b1;
         end
         state_nxt = '0;
      end else if (state_cur.bytes_pending != utf8d_pkg::PEND_NONE) begin
         state_nxt.bytes_pending = state_cur.bytes_pending - utf8d_pkg::PEND_ONE;
         state_nxt.partial_code  = merged;
         if (state_cur.bytes_pending == utf8d_pkg::PEND_ONE) begin
            emit                   = 1'b1;
            result.code_point      = merged;
            result.has_code        = 1'b1;
            state_nxt.partial_code = '0;
         end
      end else if (!text_byte[7]) begin
         emit              = 1'b1;
         result.code_point = {13'h0000, text_byte};
         result.has_code   = 1'b1;
      end else if (text_byte[7:5] == 3'b110) begin
         state_nxt.partial_code  = {10'h000, text_byte[4:0], 6'h00};
         state_nxt.bytes_pending = utf8d_pkg::PEND_ONE;
      end else if (text_byte[7:4] == 4'b1110) begin
         state_nxt.partial_code  = {5'h00, text_byte[3:0], 12'h000};
         state_nxt.bytes_pending = utf8d_pkg::PEND_TWO;
      end else begin
         // stray continuation and 0xf8-0xff also land here
         state_nxt.partial_code  = {text_byte[2:0], 18'h00000};
         state_nxt.bytes_pending = utf8d_pkg::PEND_THREE;
      end
   end

endmodule

@@ design/utf8_codepoint_decoder.sv @@
// top level of the streaming utf-8 code point decoder
// Takes one byte per item and returns a code point item when a sequence
// completes, or an end item on a zero byte. Every byte is registered on
// entry, decoded against the partial code point state, and the result is
// registered on exit, so a byte is accepted every cycle; a closing byte is
// held in the input register, then its result in the output register.
// Bytes that only open or extend a sequence produce no result item.
// Throughput drops only while the result register is held by rsp_ready low.
module utf8_codepoint_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [utf8d_pkg::ByteWidth-1:0]     req_text_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utf8d_pkg::CodeWidth-1:0]     rsp_code_point,
   output logic                                rsp_has_code,
   output logic                                rsp_string_end
);

   logic                            in_valid_ff, in_valid_in;
   logic [utf8d_pkg::ByteWidth-1:0] in_byte_ff;
   utf8d_pkg::state_type            state_ff, state_in;
   logic                            out_valid_ff, out_valid_in;
   utf8d_pkg::result_type           out_ff;

   utf8d_pkg::state_type            step_state;
   utf8d_pkg::result_type           step_result;
   logic                            step_emit;
   logic                            advance;
   logic                            load_out;

   utf8d_step u_step (
      .text_byte (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (step_state),
      .emit      (step_emit),
      .result    (step_result)
   );

   // staged item moves on unless its result has nowhere to go
   assign advance   = in_valid_ff && (!step_emit || !out_valid_ff || rsp_ready);
   assign load_out  = advance && step_emit;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign state_in     = advance ? step_state : state_ff;
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
      end
      if (load_out) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_ff.code_point;
   assign rsp_has_code   = out_ff.has_code;
   assign rsp_string_end = out_ff.string_end;

   // a bare end mark carries no code point
   a_bare_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_code |-> rsp_string_end && rsp_code_point == '0)
      else $error("bare end item with code point bits");

   // a zero byte leaves the decoder idle
   a_zero_idle : assert property (@(posedge clock) disable iff (reset)
      advance && in_byte_ff == '0 |=> state_ff == '0)
      else $error("state not cleared by zero byte");

   // bits not yet gathered stay clear
   a_partial_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending != utf8d_pkg::PEND_NONE || state_ff.partial_code == '0) &&
      (state_ff.bytes_pending != utf8d_pkg::PEND_ONE || state_ff.partial_code[5:0] == '0) &&
      (state_ff.bytes_pending != utf8d_pkg::PEND_TWO || state_ff.partial_code[11:0] == '0))
      else $error("partial code point has bits below the pending position");

endmodule
